### sv/bmm_pkg.sv
// shared constants, types and helpers for the banked memory mapper
`timescale 1ns / 1ps

package bmm_pkg;

  localparam int SYS_RAM_BYTES_DEF = 8192;
  localparam int CART_RAM_BYTES    = 16384;
  localparam int ROM_AW            = 22;
  localparam int PAGE_W            = 8;
  localparam int BANKS_W           = 9;
  localparam int OFS_W             = 14;

  localparam logic [BANKS_W-1:0] BANKS_RESET = 9'd2;

  // bus opcodes
  localparam logic [1:0] OP_READ       = 2'd0;
  localparam logic [1:0] OP_WRITE_BYTE = 2'd1;
  localparam logic [1:0] OP_WRITE_WORD = 2'd2;

  // result targets
  localparam logic [1:0] TGT_ROM  = 2'd0;
  localparam logic [1:0] TGT_CART = 2'd1;
  localparam logic [1:0] TGT_SYS  = 2'd2;
  localparam logic [1:0] TGT_NONE = 2'd3;

  // paging register addresses
  localparam logic [15:0] REG_CTRL  = 16'hFFFC;
  localparam logic [15:0] REG_SLOT0 = 16'hFFFD;
  localparam logic [15:0] REG_SLOT1 = 16'hFFFE;
  localparam logic [15:0] REG_SLOT2 = 16'hFFFF;

  // region and control bits
  localparam logic [15:0] UNPAGED_END = 16'h0400;
  localparam logic [1:0]  REGION_HI   = 2'b11;
  localparam logic [1:0]  REGION_S2   = 2'b10;
  localparam logic [1:0]  REGION_S1   = 2'b01;
  localparam int          CTRL_EN_BIT   = 3;
  localparam int          CTRL_PAGE_BIT = 2;

  typedef struct packed {
    logic capture;
    logic clr_step;
    logic mem_op;
    logic word_hi;
    logic div_start;
    logic div_step;
    logic load_out;
  } bmm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic word_sys;
    logic page_write;
    logic div_last;
    logic out_free;
  } bmm_status_t;

  // offset modulo ram size; offset is below 16 times any legal size
  function automatic logic [OFS_W-1:0] sys_mod(input logic [OFS_W-1:0] v, input int depth);
    logic [17:0] r;
    logic [17:0] d;
    begin
      r = {4'b0, v};
      for (int k = 3; k >= 0; k--) begin
        d = 18'(depth) << k;
        if (r >= d) r = r - d;
      end
      return r[OFS_W-1:0];
    end
  endfunction

endpackage

### sv/bmm_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps

module bmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end

endmodule

### sv/bmm_ctrl.sv
// sequencing state machine of the banked memory mapper
`timescale 1ns / 1ps

module bmm_ctrl import bmm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  bmm_status_t status,
  output bmm_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_HIGH,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      case (state)
        ST_CLEAR:  if (status.clr_last) state <= ST_IDLE;
        ST_IDLE:   if (in_valid) state <= ST_EXEC;
        ST_EXEC: begin
          if (status.word_sys) state <= ST_HIGH;
          else if (status.page_write) state <= ST_DIV;
          else state <= ST_FINISH;
        end
        ST_HIGH:   state <= ST_FINISH;
        ST_DIV:    if (status.div_last) state <= ST_FINISH;
        ST_FINISH: if (status.out_free) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state == ST_IDLE) && in_valid;
    cmd.clr_step  = (state == ST_CLEAR);
    cmd.mem_op    = (state == ST_EXEC);
    cmd.div_start = (state == ST_EXEC) && status.page_write;
    cmd.word_hi   = (state == ST_HIGH);
    cmd.div_step  = (state == ST_DIV);
    cmd.load_out  = (state == ST_FINISH) && status.out_free;
  end

endmodule

### sv/bmm_datapath.sv
// address decode, paging registers, rams, bank modulo and result register
`timescale 1ns / 1ps

module bmm_datapath import bmm_pkg::*; #(
  parameter int SYSTEM_RAM_BYTES = SYS_RAM_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bmm_cmd_t           cmd,
  output bmm_status_t        status,
  input  logic [1:0]         in_opcode,
  input  logic [15:0]        in_address,
  input  logic [15:0]        in_data,
  input  logic               cfg_we,
  input  logic [BANKS_W-1:0] cfg_banks,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_target,
  output logic [ROM_AW-1:0]  out_rom_address,
  output logic [7:0]         out_read_data
);

  localparam int SAW = $clog2(SYSTEM_RAM_BYTES);
  localparam logic [SAW:0]   SYS_SIZE = (SAW+1)'(SYSTEM_RAM_BYTES);
  localparam logic [SAW-1:0] SYS_TOP  = SAW'(SYSTEM_RAM_BYTES - 1);

  logic [1:0]  op;
  logic [15:0] addr;
  logic [15:0] data;

  logic [BANKS_W-1:0] rom_banks;
  logic [PAGE_W-1:0]  slot0_page, slot1_page, slot2_page;
  logic               cart_en, cart_page;

  logic [SAW-1:0] clr_cnt;

  // bank modulo state
  logic [PAGE_W-1:0]  div_q;
  logic [BANKS_W-1:0] div_rem;
  logic [2:0]         div_cnt;
  logic [BANKS_W:0]   div_try;
  logic [BANKS_W-1:0] banks_eff;

  logic        is_hi, is_cart, is_reg;
  logic [1:0]  target;
  logic [ROM_AW-1:0] rom_addr;
  logic [OFS_W-1:0]  sys_off;
  logic [SAW-1:0]    sys_idx, sys_idx2;
  logic [SAW:0]      sys_inc;

  logic           sys_we, sys_re, cart_we, cart_re;
  logic [SAW-1:0] sys_addr;
  logic [7:0]     sys_wdata, sys_rdata, cart_rdata;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= in_opcode;
      addr <= in_address;
      data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rom_banks <= BANKS_RESET;
    else if (cfg_we) rom_banks <= cfg_banks;
  end

  // decode of the held access
  assign is_hi   = (addr[15:14] == REGION_HI);
  assign is_cart = (addr[15:14] == REGION_S2) && cart_en;
  assign is_reg  = (op == OP_WRITE_BYTE) &&
                   (addr == REG_SLOT0 || addr == REG_SLOT1 || addr == REG_SLOT2);

  always_comb begin
    case (op)
      OP_READ:       target = is_hi ? TGT_SYS : (is_cart ? TGT_CART : TGT_ROM);
      OP_WRITE_BYTE: target = is_hi ? TGT_SYS : (is_cart ? TGT_CART : TGT_NONE);
      OP_WRITE_WORD: target = is_hi ? TGT_SYS : TGT_NONE;
      default:       target = TGT_NONE;
    endcase
  end

  always_comb begin
    if (addr < UNPAGED_END) rom_addr = ROM_AW'(addr);
    else begin
      case (addr[15:14])
        REGION_S2: rom_addr = {slot2_page, addr[13:0]};
        REGION_S1: rom_addr = {slot1_page, addr[13:0]};
        default:   rom_addr = {slot0_page, addr[13:0]};
      endcase
    end
  end

  assign sys_off  = sys_mod(addr[13:0], SYSTEM_RAM_BYTES);
  assign sys_idx  = sys_off[SAW-1:0];
  assign sys_inc  = {1'b0, sys_idx} + 1'b1;
  assign sys_idx2 = (sys_inc == SYS_SIZE) ? '0 : sys_inc[SAW-1:0];

  // system ram port: clear sweep, high byte of a word, or the access itself
  always_comb begin
    sys_we    = 1'b0;
    sys_re    = 1'b0;
    sys_addr  = sys_idx;
    sys_wdata = data[7:0];
    if (cmd.clr_step) begin
      sys_we    = 1'b1;
      sys_addr  = clr_cnt;
      sys_wdata = '0;
    end else if (cmd.word_hi) begin
      sys_we    = 1'b1;
      sys_addr  = sys_idx2;
      sys_wdata = data[15:8];
    end else if (cmd.mem_op && target == TGT_SYS) begin
      sys_we = (op != OP_READ);
      sys_re = (op == OP_READ);
    end
  end

  assign cart_we = cmd.mem_op && target == TGT_CART && op == OP_WRITE_BYTE;
  assign cart_re = cmd.mem_op && target == TGT_CART && op == OP_READ;

  bmm_ram #(.WIDTH(8), .DEPTH(SYSTEM_RAM_BYTES)) u_sys_ram (
    .clk   (clk),
    .we    (sys_we),
    .re    (sys_re),
    .addr  (sys_addr),
    .wdata (sys_wdata),
    .rdata (sys_rdata)
  );

  bmm_ram #(.WIDTH(8), .DEPTH(CART_RAM_BYTES)) u_cart_ram (
    .clk   (clk),
    .we    (cart_we),
    .re    (cart_re),
    .addr  ({cart_page, addr[12:0]}),
    .wdata (data[7:0]),
    .rdata (cart_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
  end

  // restoring remainder, one dividend bit per cycle, msb first
  assign banks_eff = (rom_banks == '0) ? BANKS_W'(1) : rom_banks;
  assign div_try   = {div_rem, div_q[PAGE_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q   <= data[7:0];
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_q   <= div_q << 1;
      div_cnt <= div_cnt + 1'b1;
      if (div_try >= {1'b0, banks_eff}) div_rem <= BANKS_W'(div_try - {1'b0, banks_eff});
      else div_rem <= div_try[BANKS_W-1:0];
    end
  end

  logic [BANKS_W:0] div_fin;
  assign div_fin = (div_try >= {1'b0, banks_eff}) ? div_try - {1'b0, banks_eff} : div_try;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot0_page <= PAGE_W'(0);
      slot1_page <= PAGE_W'(1);
      slot2_page <= PAGE_W'(2);
      cart_en    <= 1'b0;
      cart_page  <= 1'b0;
    end else begin
      if (cmd.mem_op && op == OP_WRITE_BYTE && addr == REG_CTRL) begin
        cart_en   <= data[CTRL_EN_BIT];
        cart_page <= data[CTRL_PAGE_BIT];
      end
      if (cmd.div_step && status.div_last) begin
        case (addr)
          REG_SLOT0: slot0_page <= div_fin[PAGE_W-1:0];
          REG_SLOT1: slot1_page <= div_fin[PAGE_W-1:0];
          REG_SLOT2: slot2_page <= div_fin[PAGE_W-1:0];
          default:   ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_target      <= target;
      out_rom_address <= (target == TGT_ROM) ? rom_addr : '0;
      if (op == OP_READ && target == TGT_SYS) out_read_data <= sys_rdata;
      else if (op == OP_READ && target == TGT_CART) out_read_data <= cart_rdata;
      else out_read_data <= '0;
    end
  end

  assign status.clr_last   = (clr_cnt == SYS_TOP);
  assign status.word_sys   = (op == OP_WRITE_WORD) && is_hi;
  assign status.page_write = is_reg;
  assign status.div_last   = (div_cnt == 3'd7);
  assign status.out_free   = !out_valid || out_ready;

endmodule

### sv/banked_memory_mapper.sv
// top level of the banked memory mapper
`timescale 1ns / 1ps

// Translates cpu bus accesses of a cartridge console: rom address output,
// cartridge ram and system ram inside, paging registers at 0xFFFC..0xFFFF.
// Input channel s_*: one beat per bus access (opcode in s_tuser).
// Output channel m_*: one beat per access (target in m_tuser).
// cfg_*: rom size in 16 KB banks, write only while the block is idle.
// Steps: an access is captured, then the rams are accessed, then the result
// is loaded into the output register; a word write to system ram adds a
// second byte write (one ram port, two byte writes), and a slot page write
// runs the bit-serial bank modulo unit before the result load.
// One access is worked on at a time; the next input beat is taken as soon
// as the previous result sits in the output register, even if m_tready is
// low. s_tready is low while an access is worked on, and a finished result
// waits while the output register is still full.
// Reset: paging registers return to slots 0/1/2 and rom_banks to 2, then a
// clearing pass writes zero through all SYSTEM_RAM_BYTES bytes of system
// ram (8192 by default), one byte per cycle, with s_tready low; cfg writes
// are taken during that pass. Cartridge ram is not cleared.

module banked_memory_mapper import bmm_pkg::*; #(
  parameter int SYSTEM_RAM_BYTES = SYS_RAM_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input beats
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [31:0]        s_tdata,   // [15:0] address, [31:16] data
  input  logic [1:0]         s_tuser,   // [1:0] opcode
  // result beats
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,   // [21:0] rom_address, [29:22] read_data, [31:30] zero
  output logic [1:0]         m_tuser,   // [1:0] target
  // rom size register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [BANKS_W-1:0] cfg_data
);

  bmm_cmd_t    cmd;
  bmm_status_t status;

  logic [ROM_AW-1:0] rom_address;
  logic [7:0]        read_data;

  // the register is always writable
  assign cfg_ready = 1'b1;

  bmm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bmm_datapath #(.SYSTEM_RAM_BYTES(SYSTEM_RAM_BYTES)) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_opcode       (s_tuser),
    .in_address      (s_tdata[15:0]),
    .in_data         (s_tdata[31:16]),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_banks       (cfg_data),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .out_target      (m_tuser),
    .out_rom_address (rom_address),
    .out_read_data   (read_data)
  );

  // pack the result beat
  assign m_tdata = {2'b00, read_data, rom_address};

  // no input beat while system ram is still being cleared after reset
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("input taken during system ram clear");

  // only one access in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second access taken while one is in flight");

  // rom address only on rom results
  a_rom_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != TGT_ROM) |-> (m_tdata[21:0] == '0))
    else $error("rom address set on a non-rom result");

  // read data only on ram results
  a_read_data_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == TGT_ROM || m_tuser == TGT_NONE)) |-> (m_tdata[29:22] == '0))
    else $error("read data set on a result without a ram read");

endmodule
